>>> rtl/thr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thr_pkg
// shared widths, operation and status codes for the timestamped history ring
// ----------------------------------------------------------------------------
package thr_pkg;

    localparam int OP_W      = 2;
    localparam int ENTRY_W   = 32;
    localparam int STAMP_W   = 64;
    localparam int INDEX_W   = 7;
    localparam int LIMIT_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 6;
    localparam int CFG_W     = 6;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_GET   = 2'd1;
    localparam logic [OP_W-1:0] OP_RANGE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic [ENTRY_W-1:0]        entry_in;
        logic [STAMP_W-1:0]        push_stamp;
        logic signed [INDEX_W-1:0] read_index;
        logic [STAMP_W-1:0]        start_time;
        logic [STAMP_W-1:0]        end_time;
        logic                      want_entries;
        logic [LIMIT_W-1:0]        out_limit;
    } t_cmd;

endpackage

>>> rtl/thr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thr_if
// request, result and configuration channels of the history ring
// ----------------------------------------------------------------------------
interface thr_in_if;
    logic                               valid;
    logic                               ready;
    logic [thr_pkg::OP_W-1:0]           opcode;
    logic [thr_pkg::ENTRY_W-1:0]        entry_in;
    logic [thr_pkg::STAMP_W-1:0]        push_stamp;
    logic signed [thr_pkg::INDEX_W-1:0] read_index;
    logic [thr_pkg::STAMP_W-1:0]        start_time;
    logic [thr_pkg::STAMP_W-1:0]        end_time;
    logic                               want_entries;
    logic [thr_pkg::LIMIT_W-1:0]        out_limit;

    modport source (output valid, opcode, entry_in, push_stamp, read_index,
                    start_time, end_time, want_entries, out_limit, input ready);
    modport sink   (input valid, opcode, entry_in, push_stamp, read_index,
                    start_time, end_time, want_entries, out_limit, output ready);
endinterface

interface thr_out_if;
    logic                          valid;
    logic                          ready;
    logic [thr_pkg::STATUS_W-1:0]  status;
    logic                          has_entry;
    logic [thr_pkg::ENTRY_W-1:0]   entry_out;
    logic [thr_pkg::STAMP_W-1:0]   entry_stamp;
    logic [thr_pkg::COUNT_W-1:0]   match_count;
    logic                          last;

    modport source (output valid, status, has_entry, entry_out, entry_stamp,
                    match_count, last, input ready);
    modport sink   (input valid, status, has_entry, entry_out, entry_stamp,
                    match_count, last, output ready);
endinterface

interface thr_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [thr_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/thr_ring_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thr_ring_mem
// entry and stamp store, one write port and one registered read port
// ----------------------------------------------------------------------------
module thr_ring_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/thr_slot_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thr_slot_map
// maps a logical position (0 oldest) to a physical ring slot
// ----------------------------------------------------------------------------
module thr_slot_map #(
    parameter int DEPTH = 32
) (
    input  logic [$clog2(DEPTH+1)-1:0] i_logical,
    input  logic [$clog2(DEPTH)-1:0]   i_wp,
    input  logic [$clog2(DEPTH+1)-1:0] i_cap,
    input  logic                       i_full,
    output logic [$clog2(DEPTH)-1:0]   o_addr
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW:0] sum;
    logic [CW:0] wrapped;

    always_comb begin
        sum     = (CW + 1)'(i_wp) + (CW + 1)'(i_logical);
        wrapped = (sum >= (CW + 1)'(i_cap)) ? sum - (CW + 1)'(i_cap) : sum;
        if (i_full) begin
            o_addr = wrapped[AW-1:0];
        end else begin
            o_addr = i_logical[AW-1:0];
        end
    end

endmodule

>>> rtl/timestamped_history_ring_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_history_ring_top
// overwrite-oldest ring of timestamped entries with push, get, range, clear
//
//   channel  modport  transaction
//   i_in     sink     one request: opcode and operands
//   o_out    source   one result; last marks the final result of a request
//   i_cfg    sink     ring capacity write, also empties the ring
//
// push, clear: done in S_EXEC; get: one registered memory read, S_EXEC then S_GETW
// range: S_RRD/S_RCMP walk the filled slots (not with reversed bounds), one slot read
//   and one stamp compare per step through the single memory read port
// i_rst_n is synchronous; no clearing pass, the store is read only once written
// a stalled o_out holds the sequencer in place, no result is dropped
// ----------------------------------------------------------------------------
module timestamped_history_ring_top #(
    parameter int DEPTH       = 32,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    thr_in_if.sink   i_in,
    thr_out_if.source o_out,
    thr_cfg_if.sink  i_cfg
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int EW      = (ENTRY_WIDTH < thr_pkg::ENTRY_W) ? ENTRY_WIDTH
                                                              : thr_pkg::ENTRY_W;
    localparam int MW      = EW + thr_pkg::STAMP_W;
    localparam int CAP_RST = (DEPTH < 32) ? DEPTH : 32;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_GETW = 3'd2;
    localparam logic [2:0] S_RRD  = 3'd3;
    localparam logic [2:0] S_RCMP = 3'd4;
    localparam logic [2:0] S_RSUM = 3'd5;

    logic [2:0]          r_state, n_state;
    thr_pkg::t_cmd       r_cmd;
    logic [AW-1:0]       r_wp, n_wp;
    logic [CW-1:0]       r_fill, n_fill;
    logic [CW-1:0]       r_cap;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_matched, n_matched;
    logic [CW-1:0]       r_written, n_written;

    logic                              r_out_valid;
    logic [thr_pkg::STATUS_W-1:0]      r_status;
    logic                              r_has_entry;
    logic [thr_pkg::ENTRY_W-1:0]       r_entry_out;
    logic [thr_pkg::STAMP_W-1:0]       r_entry_stamp;
    logic [thr_pkg::COUNT_W-1:0]       r_match_count;
    logic                              r_last;

    logic                              emit;
    logic [thr_pkg::STATUS_W-1:0]      e_status;
    logic                              e_has;
    logic [thr_pkg::COUNT_W-1:0]       e_count;
    logic                              e_last;

    logic                              free;
    logic                              in_acc;
    logic                              wr_en;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    logic [CW-1:0]                     map_log;
    logic [MW-1:0]                     rd_data;
    logic [EW-1:0]                     rd_entry;
    logic [thr_pkg::STAMP_W-1:0]       rd_stamp;
    logic                              hit;
    logic                              bad_range;
    logic                              want_emit;
    logic signed [7:0]                 idx_x;
    logic signed [7:0]                 n_s;
    logic signed [7:0]                 adj;
    logic signed [7:0]                 get_log_x;
    logic                              get_ok;
    logic [CW-1:0]                     cfg_cap;

    assign free        = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign rd_entry  = rd_data[MW-1:thr_pkg::STAMP_W];
    assign rd_stamp  = rd_data[thr_pkg::STAMP_W-1:0];
    assign hit       = (rd_stamp >= r_cmd.start_time) && (rd_stamp <= r_cmd.end_time);
    assign bad_range = r_cmd.start_time > r_cmd.end_time;
    assign want_emit = r_cmd.want_entries && (8'(r_written) < r_cmd.out_limit);

    // get index: non-negative counts from the newest, negative from the oldest
    always_comb begin
        idx_x     = 8'($signed(r_cmd.read_index));
        n_s       = 8'(r_fill);
        adj       = idx_x[7] ? idx_x + n_s : idx_x;
        get_ok    = (r_fill != '0) && !adj[7] && (adj < n_s);
        get_log_x = n_s - 8'sd1 - adj;
    end

    always_comb begin
        if (i_cfg.data == '0) begin
            cfg_cap = CW'(1);
        end else if (8'(i_cfg.data) > 8'(DEPTH)) begin
            cfg_cap = CW'(DEPTH);
        end else begin
            cfg_cap = CW'(i_cfg.data);
        end
    end

    assign map_log = (r_state == S_EXEC) ? get_log_x[CW-1:0] : r_i;

    thr_slot_map #(
        .DEPTH (DEPTH)
    ) u_map (
        .i_logical (map_log),
        .i_wp      (r_wp),
        .i_cap     (r_cap),
        .i_full    (r_fill == r_cap),
        .o_addr    (rd_addr)
    );

    thr_ring_mem #(
        .DEPTH (DEPTH),
        .WIDTH (MW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data ({r_cmd.entry_in[EW-1:0], r_cmd.push_stamp}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_fill    = r_fill;
        n_i       = r_i;
        n_matched = r_matched;
        n_written = r_written;
        emit      = 1'b0;
        e_status  = thr_pkg::ST_OK;
        e_has     = 1'b0;
        e_count   = '0;
        e_last    = 1'b1;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd.opcode)
                    thr_pkg::OP_PUSH: begin
                        if (free) begin
                            wr_en   = 1'b1;
                            emit    = 1'b1;
                            n_wp    = (CW'(r_wp) + CW'(1) == r_cap) ? '0 : r_wp + AW'(1);
                            n_fill  = (r_fill < r_cap) ? r_fill + CW'(1) : r_fill;
                            n_state = S_IDLE;
                        end
                    end
                    thr_pkg::OP_GET: begin
                        if (get_ok) begin
                            rd_en   = 1'b1;
                            n_state = S_GETW;
                        end else if (free) begin
                            emit     = 1'b1;
                            e_status = thr_pkg::ST_NOT_FOUND;
                            n_state  = S_IDLE;
                        end
                    end
                    thr_pkg::OP_RANGE: begin
                        n_i       = '0;
                        n_matched = '0;
                        n_written = '0;
                        if (!bad_range) begin
                            n_state = S_RRD;
                        end else if (free) begin
                            emit     = 1'b1;
                            e_status = thr_pkg::ST_INVALID;
                            n_state  = S_IDLE;
                        end
                    end
                    default: begin
                        if (free) begin
                            emit    = 1'b1;
                            n_wp    = '0;
                            n_fill  = '0;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_GETW: begin
                if (free) begin
                    emit    = 1'b1;
                    e_has   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RRD: begin
                if (r_i == r_fill) begin
                    n_state = S_RSUM;
                end else begin
                    rd_en   = 1'b1;
                    n_i     = r_i + CW'(1);
                    n_state = S_RCMP;
                end
            end
            S_RCMP: begin
                if (!hit) begin
                    n_state = S_RRD;
                end else if (!want_emit) begin
                    n_matched = r_matched + CW'(1);
                    n_state   = S_RRD;
                end else if (free) begin
                    emit      = 1'b1;
                    e_has     = 1'b1;
                    e_last    = 1'b0;
                    n_matched = r_matched + CW'(1);
                    n_written = r_written + CW'(1);
                    n_state   = S_RRD;
                end
            end
            S_RSUM: begin
                if (free) begin
                    emit     = 1'b1;
                    e_count  = thr_pkg::COUNT_W'(r_matched);
                    e_status = (r_cmd.want_entries && (8'(r_matched) > r_cmd.out_limit))
                               ? thr_pkg::ST_TOO_SMALL : thr_pkg::ST_OK;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_cap       <= CW'(CAP_RST);
            r_i         <= '0;
            r_matched   <= '0;
            r_written   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_matched <= n_matched;
            r_written <= n_written;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap  <= cfg_cap;
                r_wp   <= '0;
                r_fill <= '0;
            end else begin
                r_wp   <= n_wp;
                r_fill <= n_fill;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd.opcode       <= i_in.opcode;
            r_cmd.entry_in     <= i_in.entry_in;
            r_cmd.push_stamp   <= i_in.push_stamp;
            r_cmd.read_index   <= i_in.read_index;
            r_cmd.start_time   <= i_in.start_time;
            r_cmd.end_time     <= i_in.end_time;
            r_cmd.want_entries <= i_in.want_entries;
            r_cmd.out_limit    <= i_in.out_limit;
        end
        if (emit) begin
            r_status      <= e_status;
            r_has_entry   <= e_has;
            r_entry_out   <= e_has ? thr_pkg::ENTRY_W'(rd_entry) : '0;
            r_entry_stamp <= e_has ? rd_stamp : '0;
            r_match_count <= e_count;
            r_last        <= e_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.has_entry   = r_has_entry;
    assign o_out.entry_out   = r_entry_out;
    assign o_out.entry_stamp = r_entry_stamp;
    assign o_out.match_count = r_match_count;
    assign o_out.last        = r_last;

`ifndef SYNTH
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_cap)
        else $error("fill count above capacity");
    a_wp_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_wp) < r_cap)
        else $error("write pointer outside ring");
    a_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_written <= r_matched)
        else $error("emitted more entries than matched");
    a_mid_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> r_has_entry)
        else $error("non-final result without entry");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted request not dispatched");
`endif

endmodule
